[hw/rtl/iadf_pkg.sv]
// shared constants and types for the indexed array insert/delete/find block
package iadf_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int POS_W      = 12;
    localparam int VALUE_W    = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 10;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
    } mem_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage

[hw/rtl/iadf_if.sv]
// request and response channel interfaces
interface iadf_req_if;
    logic                                valid;
    logic                                ready;
    logic [iadf_pkg::FUNC_W-1:0]         func;
    logic signed [iadf_pkg::POS_W-1:0]   position;
    logic signed [iadf_pkg::VALUE_W-1:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

interface iadf_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [iadf_pkg::STATUS_W-1:0]    status;
    logic [iadf_pkg::FOUND_W-1:0]     found_index;
    logic [iadf_pkg::COUNT_W-1:0]     count;

    modport source (output valid, status, found_index, count, input ready);
    modport sink   (input valid, status, found_index, count, output ready);
endinterface

[hw/rtl/iadf_mem.sv]
// entry store: one write port, one read port with registered read data
module iadf_mem
(
    input  logic                                clk,
    input  iadf_pkg::mem_cmd_t                  cmd,
    output logic [iadf_pkg::DATA_WIDTH-1:0]     rd_data
);

    logic [iadf_pkg::DATA_WIDTH-1:0] mem [iadf_pkg::CAPACITY];
    logic [iadf_pkg::DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/iadf_seq.sv]
// sequencer: walks the store one entry per cycle for shifts and searches
module iadf_seq
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [iadf_pkg::FUNC_W-1:0]            func,
    input  logic signed [iadf_pkg::POS_W-1:0]      position,
    input  logic signed [iadf_pkg::VALUE_W-1:0]    value,
    output logic                                   idle,
    input  logic                                   out_free,
    output logic                                   done,
    output iadf_pkg::result_t                      result,
    output iadf_pkg::mem_cmd_t                     mem_cmd,
    input  logic [iadf_pkg::DATA_WIDTH-1:0]        rd_data
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_INS_MOVE  = 9'b000000010,
        S_INS_LAST  = 9'b000000100,
        S_PUT       = 9'b000001000,
        S_DEL_MOVE  = 9'b000010000,
        S_DEL_LAST  = 9'b000100000,
        S_FIND      = 9'b001000000,
        S_FIND_LAST = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [iadf_pkg::ADDR_W-1:0]            idx_reg, idx_next;
    logic [iadf_pkg::ADDR_W-1:0]            pos_reg, pos_next;
    logic [iadf_pkg::DATA_WIDTH-1:0]        val_reg, val_next;
    logic [iadf_pkg::COUNT_W-1:0]           count_reg, count_next;
    logic                                   pend_reg, pend_next;
    logic [iadf_pkg::ADDR_W-1:0]            pend_addr_reg, pend_addr_next;
    logic [iadf_pkg::STATUS_W-1:0]          status_reg, status_next;
    logic [iadf_pkg::FOUND_W-1:0]           found_reg, found_next;

    logic [iadf_pkg::ADDR_W-1:0]            last_idx;
    logic                                   match;

    // negative goes to zero, anything above limit goes to limit
    function automatic logic [iadf_pkg::ADDR_W-1:0] clamp_pos
    (
        input logic signed [iadf_pkg::POS_W-1:0] p,
        input logic [iadf_pkg::COUNT_W-1:0]      limit
    );
        logic [iadf_pkg::COUNT_W-1:0] mag;
        mag = iadf_pkg::COUNT_W'(p[iadf_pkg::POS_W-2:0]);
        if (p[iadf_pkg::POS_W-1])
        begin
            return '0;
        end
        else if (mag > limit)
        begin
            return iadf_pkg::ADDR_W'(limit);
        end
        return iadf_pkg::ADDR_W'(mag);
    endfunction

    assign last_idx = iadf_pkg::ADDR_W'(count_reg - iadf_pkg::COUNT_W'(1));
    assign match    = (rd_data == val_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        done           = 1'b0;
        mem_cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next    = value[iadf_pkg::DATA_WIDTH-1:0];
                    status_next = iadf_pkg::STATUS_OK;
                    found_next  = '0;
                    state_next  = S_DONE;
                    unique case (func)
                        iadf_pkg::FUNC_INSERT:
                        begin
                            if (count_reg >= iadf_pkg::COUNT_W'(iadf_pkg::CAPACITY))
                            begin
                                status_next = iadf_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                pos_next = clamp_pos(position, count_reg);
                                idx_next = last_idx;
                                if (iadf_pkg::COUNT_W'(pos_next) == count_reg)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    state_next = S_INS_MOVE;
                                end
                            end
                        end
                        iadf_pkg::FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = iadf_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                pos_next = clamp_pos(position,
                                                     count_reg - iadf_pkg::COUNT_W'(1));
                                idx_next = pos_next + iadf_pkg::ADDR_W'(1);
                                if (pos_next == last_idx)
                                begin
                                    count_next = count_reg - iadf_pkg::COUNT_W'(1);
                                end
                                else
                                begin
                                    state_next = S_DEL_MOVE;
                                end
                            end
                        end
                        iadf_pkg::FUNC_FIND:
                        begin
                            status_next = iadf_pkg::STATUS_MISSING;
                            idx_next    = '0;
                            if (count_reg != '0)
                            begin
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // read from the top down, each word lands one place higher
            S_INS_MOVE:
            begin
                mem_cmd.wr_en   = pend_reg;
                mem_cmd.wr_addr = pend_addr_reg;
                mem_cmd.wr_data = rd_data;
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = idx_reg;
                pend_next       = 1'b1;
                pend_addr_next  = idx_reg + iadf_pkg::ADDR_W'(1);
                if (idx_reg == pos_reg)
                begin
                    state_next = S_INS_LAST;
                end
                else
                begin
                    idx_next = idx_reg - iadf_pkg::ADDR_W'(1);
                end
            end

            S_INS_LAST:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = pend_addr_reg;
                mem_cmd.wr_data = rd_data;
                state_next      = S_PUT;
            end

            S_PUT:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = pos_reg;
                mem_cmd.wr_data = val_reg;
                count_next      = count_reg + iadf_pkg::COUNT_W'(1);
                state_next      = S_DONE;
            end

            // read upwards from the gap, each word lands one place lower
            S_DEL_MOVE:
            begin
                mem_cmd.wr_en   = pend_reg;
                mem_cmd.wr_addr = pend_addr_reg;
                mem_cmd.wr_data = rd_data;
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = idx_reg;
                pend_next       = 1'b1;
                pend_addr_next  = idx_reg - iadf_pkg::ADDR_W'(1);
                if (idx_reg == last_idx)
                begin
                    state_next = S_DEL_LAST;
                end
                else
                begin
                    idx_next = idx_reg + iadf_pkg::ADDR_W'(1);
                end
            end

            S_DEL_LAST:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = pend_addr_reg;
                mem_cmd.wr_data = rd_data;
                count_next      = count_reg - iadf_pkg::COUNT_W'(1);
                state_next      = S_DONE;
            end

            // compare the word read last cycle while fetching the next one
            S_FIND:
            begin
                if (pend_reg && match)
                begin
                    status_next = iadf_pkg::STATUS_OK;
                    found_next  = iadf_pkg::FOUND_W'(pend_addr_reg);
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = idx_reg;
                    pend_next       = 1'b1;
                    pend_addr_next  = idx_reg;
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_FIND_LAST;
                    end
                    else
                    begin
                        idx_next = idx_reg + iadf_pkg::ADDR_W'(1);
                    end
                end
            end

            S_FIND_LAST:
            begin
                if (match)
                begin
                    status_next = iadf_pkg::STATUS_OK;
                    found_next  = iadf_pkg::FOUND_W'(pend_addr_reg);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
    end

    assign idle               = (state_reg == S_IDLE);
    assign result.status      = status_reg;
    assign result.found_index = found_reg;
    assign result.count       = count_reg;

endmodule

[hw/rtl/indexed_array_insert_delete_find.sv]
// top level: ordered word list with positional insert, delete and linear find
//
//   channel   dir   payload                          meaning
//   req       in    func, position, value            one operation per transaction
//   rsp       out   status, found_index, count       one result per request
//
// an insert shifts each entry from the position up one place, then writes the word
// (an append just writes it); a delete shifts each entry above the position down
// one place (none for the last entry); a find scans up from entry 0 to a match or
// the end; a rejected or unused operation goes straight to the result; every
// moved or compared word goes once through the store's single read and write port
// reset clears the entry count and any waiting response; stored words are not touched
// req is taken only while the sequencer is idle; a finished result sits in
// the rsp register, and req opens again as soon as that register is loaded
module indexed_array_insert_delete_find
(
    input  logic        clk,
    input  logic        rst_n,
    iadf_req_if.sink    req,
    iadf_rsp_if.source  rsp
);

    iadf_pkg::mem_cmd_t                  mem_cmd;
    iadf_pkg::result_t                   result;
    iadf_pkg::result_t                   rsp_data_reg;
    logic [iadf_pkg::DATA_WIDTH-1:0]     rd_data;
    logic                                idle;
    logic                                done;
    logic                                out_free;
    logic                                rsp_valid_reg, rsp_valid_next;

    assign req.ready = idle;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    iadf_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req.valid && idle),
        .func     (req.func),
        .position (req.position),
        .value    (req.value),
        .idle     (idle),
        .out_free (out_free),
        .done     (done),
        .result   (result),
        .mem_cmd  (mem_cmd),
        .rd_data  (rd_data)
    );

    iadf_mem u_mem
    (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_data_reg.status;
    assign rsp.found_index = rsp_data_reg.found_index;
    assign rsp.count       = rsp_data_reg.count;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the indexed array insert/delete/find block
module tb;
    import iadf_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_OPS = 300;
    localparam int FILL_LEVEL = 100;
    localparam int QUIET_TAIL = 64;
    localparam int DRAIN_WAIT = 1100;   // a little over the slowest operation
    localparam int SHOW_LIMIT = 10;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [VALUE_W-1:0] val_t;

    localparam pos_t POS_TOP    = 12'sh7ff;
    localparam pos_t POS_BOTTOM = 12'sh800;

    typedef struct {
        logic [FUNC_W-1:0] func;
        pos_t              position;
        val_t              value;
        bit                settle;   // hold back until every response is in
    } list_op_t;

    logic clk = 1'b0;
    logic rst_n;

    iadf_req_if req_ch();
    iadf_rsp_if rsp_ch();

    indexed_array_insert_delete_find dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    list_op_t pending_ops[$];
    result_t  expected_results[$];

    // shadow copy of the list
    logic [DATA_WIDTH-1:0] shadow_words [CAPACITY];
    int                    shadow_count;

    int   plan_fill;   // fill level as the stimulus is laid out
    val_t value_pool [16];

    list_op_t    sent_op;
    list_op_t    next_op;
    result_t     got_result;
    result_t     want_result;
    int          mismatches;
    int          checked_results;
    int          accepted_ops;
    int          op_tally [4];
    int          full_rejects;
    int          empty_rejects;
    int          find_misses;
    int          peak_fill;
    int          send_gap;
    int          take_gap;
    bit          quiet_tail;
    int unsigned cyc_no;
    logic        idle_allowed;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
        cyc_no <= cyc_no + 1;

    // idle bursts stop in regular stretches and for the last part of the run
    assign idle_allowed = !quiet_tail && (cyc_no[9:8] != 2'b11);

    function automatic int clip_position(pos_t p, int limit);
        if (p < 0)
            return 0;
        if (int'(p) > limit)
            return limit;
        return int'(p);
    endfunction

    function automatic result_t apply_list_op(list_op_t op);
        result_t               r;
        int                    pos;
        bit                    hit;
        logic [DATA_WIDTH-1:0] word;

        r.status      = STATUS_OK;
        r.found_index = '0;
        word          = op.value[DATA_WIDTH-1:0];
        hit           = 1'b0;
        op_tally[op.func]++;
        case (op.func)
            FUNC_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    r.status = STATUS_FULL;
                    full_rejects++;
                end
                else
                begin
                    pos = clip_position(op.position, shadow_count);
                    for (int i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[pos] = word;
                    shadow_count++;
                end
            end
            FUNC_DELETE:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_rejects++;
                end
                else
                begin
                    pos = clip_position(op.position, shadow_count - 1);
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                end
            end
            FUNC_FIND:
            begin
                r.status = STATUS_MISSING;
                for (int i = 0; i < shadow_count && !hit; i++)
                begin
                    if (shadow_words[i] == word)
                    begin
                        hit           = 1'b1;
                        r.status      = STATUS_OK;
                        r.found_index = FOUND_W'(i);
                    end
                end
                if (!hit)
                    find_misses++;
            end
            default:
            begin
            end
        endcase
        if (shadow_count > peak_fill)
            peak_fill = shadow_count;
        r.count = COUNT_W'(shadow_count);
        return r;
    endfunction

    task automatic log_mismatch(string why, result_t want, result_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("%0t mismatch (%s): status %0d/%0d index %0d/%0d count %0d/%0d (exp/act)",
                     $time, why, want.status, got.status, want.found_index, got.found_index,
                     want.count, got.count);
    endtask

    task automatic plan_op(logic [FUNC_W-1:0] func, pos_t position, val_t value,
                           bit settle = 1'b0);
        list_op_t op;

        op.func     = func;
        op.position = position;
        op.value    = value;
        op.settle   = settle;
        pending_ops.push_back(op);
        if (func == FUNC_INSERT && plan_fill < CAPACITY)
            plan_fill++;
        else if (func == FUNC_DELETE && plan_fill > 0)
            plan_fill--;
    endtask

    function automatic pos_t pick_position(int fill);
        case ($urandom_range(0, 7))
            0:       return pos_t'($urandom);
            1:       return -pos_t'($urandom_range(1, 1024));
            2:       return pos_t'(fill + $urandom_range(0, 1100));
            default: return pos_t'($urandom_range(0, fill));
        endcase
    endfunction

    function automatic val_t pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 15)];
        return val_t'($urandom);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.func     <= FUNC_INSERT;
            req_ch.position <= '0;
            req_ch.value    <= '0;
            quiet_tail      <= 1'b0;
            send_gap        = 0;
        end
        else
        begin
            quiet_tail <= pending_ops.size() < QUIET_TAIL;
            if (req_ch.valid && req_ch.ready)
            begin
                sent_op.func     = req_ch.func;
                sent_op.position = req_ch.position;
                sent_op.value    = req_ch.value;
                sent_op.settle   = 1'b0;
                expected_results.push_back(apply_list_op(sent_op));
                accepted_ops++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (idle_allowed && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 15);
                    req_ch.valid <= 1'b0;
                end
                else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].settle && expected_results.size() != 0))
                begin
                    next_op = pending_ops.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.func     <= next_op.func;
                    req_ch.position <= next_op.position;
                    req_ch.value    <= next_op.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            take_gap     = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_result.status      = rsp_ch.status;
                got_result.found_index = rsp_ch.found_index;
                got_result.count       = rsp_ch.count;
                if (expected_results.size() == 0)
                    log_mismatch("no request outstanding", '0, got_result);
                else
                begin
                    want_result = expected_results.pop_front();
                    checked_results++;
                    if (got_result !== want_result)
                        log_mismatch("wrong result", want_result, got_result);
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_allowed && $urandom_range(0, 9) == 0)
            begin
                take_gap = $urandom_range(0, 15);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        val_t fill_base;
        int   bias;
        int   grow;
        int   k;

        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_INSERT;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        rst_n           = 1'b0;

        for (int i = 0; i < 16; i++)
            value_pool[i] = val_t'($urandom);
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = '1;

        // edges of the position range, duplicates, empty store, unused code
        plan_op(FUNC_DELETE, 0, 0);
        plan_op(FUNC_FIND, 0, 0);
        plan_op(FUNC_UNUSED, POS_TOP, 32'sh7fff_ffff);
        plan_op(FUNC_INSERT, pos_t'(-1024), 32'sh8000_0000);
        plan_op(FUNC_INSERT, POS_TOP, 32'sh7fff_ffff);
        plan_op(FUNC_INSERT, 1, -1);
        plan_op(FUNC_INSERT, POS_BOTTOM, 32'sh7fff_ffff);
        plan_op(FUNC_INSERT, pos_t'(1024), 0);
        plan_op(FUNC_FIND, POS_BOTTOM, 32'sh7fff_ffff);
        plan_op(FUNC_FIND, 0, -1);
        plan_op(FUNC_FIND, POS_TOP, 0);
        plan_op(FUNC_FIND, 0, 32'sh1234_5678);
        plan_op(FUNC_UNUSED, 0, -1);
        plan_op(FUNC_DELETE, pos_t'(1024), 0);
        plan_op(FUNC_DELETE, -1, 0);
        plan_op(FUNC_DELETE, 1, 0);
        plan_op(FUNC_INSERT, 2, 32'sh5555_5555);
        plan_op(FUNC_INSERT, 0, 32'shaaaa_aaaa);
        plan_op(FUNC_FIND, 0, 32'shaaaa_aaaa);
        plan_op(FUNC_FIND, 0, 32'sh5555_5555);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS / 2)
            begin
                // empty the list, fill it deep, work near the top, drain again
                while (plan_fill > 0)
                    plan_op(FUNC_DELETE, POS_TOP, pick_value());
                plan_op(FUNC_DELETE, pick_position(0), pick_value());
                fill_base = val_t'($urandom);
                for (int i = 0; i < FILL_LEVEL; i++)
                    plan_op(FUNC_INSERT,
                            (i % 10 == 5) ? pos_t'($urandom_range(0, plan_fill))
                                          : pos_t'($urandom_range(plan_fill, 2047)),
                            fill_base + i, i == 0);
                plan_op(FUNC_INSERT, 0, pick_value(), 1'b1);
                plan_op(FUNC_INSERT, POS_TOP, pick_value());
                plan_op(FUNC_UNUSED, pick_position(plan_fill), pick_value());
                plan_op(FUNC_FIND, 0, fill_base + (FILL_LEVEL - 1));
                plan_op(FUNC_FIND, 0, fill_base + FILL_LEVEL / 2);
                plan_op(FUNC_FIND, 0, fill_base);
                plan_op(FUNC_FIND, 0, fill_base - 1);
                for (int i = 0; i < 6; i++)
                    plan_op(FUNC_FIND, pick_position(plan_fill),
                            fill_base + $urandom_range(0, FILL_LEVEL - 1));
                plan_op(FUNC_DELETE, POS_BOTTOM, 0);
                plan_op(FUNC_INSERT, 0, pick_value());
                plan_op(FUNC_DELETE, pos_t'(600), 0);
                plan_op(FUNC_INSERT, -pos_t'(5), pick_value());
                plan_op(FUNC_DELETE, POS_TOP, 0);
                k = 0;
                while (plan_fill > 0)
                begin
                    plan_op(FUNC_DELETE,
                            (k % 128 == 7) ? pick_position(plan_fill)
                                           : pos_t'($urandom_range(plan_fill - 1, 2047)),
                            pick_value());
                    k++;
                end
                plan_op(FUNC_DELETE, pick_position(0), pick_value());
            end

            // keep the list short so that most operations stay cheap
            bias = $urandom_range(0, 99);
            grow = (plan_fill < 40) ? 50 : 25;
            if (bias < grow)
                plan_op(FUNC_INSERT, pick_position(plan_fill), pick_value(), n == 180);
            else if (bias < 75)
                plan_op(FUNC_DELETE, pick_position(plan_fill), pick_value(), n == 180);
            else if (bias < 96)
                plan_op(FUNC_FIND, pick_position(plan_fill), pick_value(), n == 180);
            else
                plan_op(FUNC_UNUSED, pick_position(plan_fill), pick_value(), n == 180);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("run: %0d operations (%0d insert, %0d delete, %0d find, %0d unused), peak fill %0d of %0d",
                 accepted_ops, op_tally[FUNC_INSERT], op_tally[FUNC_DELETE],
                 op_tally[FUNC_FIND], op_tally[FUNC_UNUSED], peak_fill, CAPACITY);
        $display("run: %0d full rejects, %0d empty rejects, %0d finds missed, %0d responses checked",
                 full_rejects, empty_rejects, find_misses, checked_results);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #150ms;
        $display("timeout: %0d requests unsent, %0d responses outstanding",
                 pending_ops.size(), expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
